FILE: sv/gf2n_pkg.sv
`default_nettype none

package gf2n_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned OPND_W = 8;
  localparam int unsigned ELEM_W = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DEG_W  = 3;
  localparam int unsigned CIDX_W = 1;
  localparam int unsigned CDAT_W = 8;

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POW = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_EXP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WIDE     = 2'd2;

  localparam logic [CIDX_W-1:0] REG_FIELD_POLY   = 1'd0;
  localparam logic [CIDX_W-1:0] REG_FIELD_DEGREE = 1'd1;

  localparam logic [OPND_W-1:0] POLY_RST = 8'd19;
  localparam logic [DEG_W-1:0]  DEG_RST  = 3'd4;

  // Field product by shift-and-add; the running multiplicand is reduced as soon
  // as its bit n appears. The top bit of the polynomial is implied.
  function automatic logic [ELEM_W-1:0] gf_mul(logic [ELEM_W-1:0] a,
                                               logic [ELEM_W-1:0] b,
                                               logic [DEG_W-1:0]  n,
                                               logic [OPND_W-1:0] poly);
    logic [OPND_W-1:0] mask;
    logic [OPND_W-1:0] low;
    logic [OPND_W-1:0] x;
    logic [OPND_W-1:0] acc;
    mask = (OPND_W'(1) << n) - OPND_W'(1);
    low  = poly & mask;
    x    = {1'b0, a} & mask;
    acc  = '0;
    for (int i = 0; i < ELEM_W; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = x << 1;
      if (x[n]) begin
        x = (x & mask) ^ low;
      end
    end
    return acc[ELEM_W-1:0] & mask[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/gf2n_if.sv
`default_nettype none

interface gf2n_in_if;
  logic                         valid;
  logic                         ready;
  logic [gf2n_pkg::ACT_W-1:0]   action;
  logic [gf2n_pkg::OPND_W-1:0]  operand_a;
  logic [gf2n_pkg::OPND_W-1:0]  operand_b;

  modport source (output valid, output action, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input action, input operand_a, input operand_b,
                output ready);
endinterface

interface gf2n_out_if;
  logic                         valid;
  logic                         ready;
  logic [gf2n_pkg::ELEM_W-1:0]  result;
  logic [gf2n_pkg::STAT_W-1:0]  status;

  modport source (output valid, output result, output status, input ready);
  modport sink (input valid, input result, input status, output ready);
endinterface

interface gf2n_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gf2n_pkg::CIDX_W-1:0]  index;
  logic [gf2n_pkg::CDAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/gf2n_field_alu_core.sv
// Add, multiply and rejected items pass from the input transfer through an
// evaluation state and a done state to the registered result; power runs, between
// those two states, one multiply and one square per exponent bit on the shared field
// multiplier for all eight bits of operand b. A new item is taken only while idle.
// Reset: asynchronous, active low; the field polynomial returns to 19 and the
// degree to 4, and the unit is idle with no result pending.
`default_nettype none

module gf2n_field_alu_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  gf2n_in_if.sink      in_i,
  gf2n_out_if.source   out_o,
  gf2n_cfg_if.sink     cfg_i
);
  import gf2n_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_PMUL = 3'd2;
  localparam logic [2:0] S_PSQR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [OPND_W-1:0] poly_q;
  logic [DEG_W-1:0]  deg_q;
  logic [DEG_W-1:0]  n_eff;

  logic [ACT_W-1:0]  act_q, act_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [ELEM_W-1:0] acc_q, acc_d;
  logic [ELEM_W-1:0] base_q, base_d;
  logic [OPND_W-1:0] exp_q, exp_d;
  logic [2:0]        cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [ELEM_W-1:0] out_res_q, out_res_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  logic [ELEM_W-1:0] mul_x, mul_y, mul_p;
  logic              in_xfer, out_free, wide_a, wide_b;

  assign n_eff    = (deg_q == '0) ? DEG_W'(1) : deg_q;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign wide_a   = (in_i.operand_a >> n_eff) != '0;
  assign wide_b   = (in_i.operand_b >> n_eff) != '0;

  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_res_q;
  assign out_o.status = out_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RST;
      deg_q  <= DEG_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FIELD_POLY:   poly_q <= cfg_i.data;
        REG_FIELD_DEGREE: deg_q  <= cfg_i.data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // The single field multiplier; its operands follow the sequencer step.
  always_comb begin
    case (state_q)
      S_PMUL: begin
        mul_x = acc_q;
        mul_y = base_q;
      end
      S_PSQR: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      default: begin
        mul_x = base_q;
        mul_y = exp_q[ELEM_W-1:0];
      end
    endcase
  end

  assign mul_p = gf_mul(mul_x, mul_y, n_eff, poly_q);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    stat_d      = stat_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_d  = in_i.action;
          base_d = in_i.operand_a[ELEM_W-1:0];
          exp_d  = in_i.operand_b;
          stat_d = STAT_OK;
          if (in_i.action == ACT_ADD || in_i.action == ACT_MUL) begin
            if (wide_a || wide_b) begin
              stat_d = STAT_WIDE;
            end
          end else if (in_i.action == ACT_POW) begin
            if (wide_a) begin
              stat_d = STAT_WIDE;
            end else if (in_i.operand_b == '0) begin
              stat_d = STAT_ZERO_EXP;
            end
          end
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_DONE;
        if (stat_q == STAT_OK) begin
          case (act_q)
            ACT_ADD: acc_d = base_q ^ exp_q[ELEM_W-1:0];
            ACT_MUL: acc_d = mul_p;
            ACT_POW: begin
              acc_d   = ELEM_W'(1);
              state_d = S_PMUL;
            end
            default: acc_d = '0;
          endcase
        end
      end
      S_PMUL: begin
        if (exp_q[0]) begin
          acc_d = mul_p;
        end
        state_d = S_PSQR;
      end
      S_PSQR: begin
        base_d = mul_p;
        exp_d  = exp_q >> 1;
        cnt_d  = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd7) ? S_DONE : S_PMUL;
      end
      S_DONE: begin
        // Waits here only while an earlier result has not yet been transferred.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    stat_q     <= stat_d;
    acc_q      <= acc_d;
    base_q     <= base_d;
    exp_q      <= exp_d;
    cnt_q      <= cnt_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q != STAT_OK) |-> (out_res_q == '0))
    else $error("error status with nonzero result");

  a_res_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (({1'b0, out_res_q} >> n_eff) == '0))
    else $error("result outside the field");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EVAL))
    else $error("transfer not followed by evaluation");

  a_pow_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSQR && cnt_q == 3'd7) |=> (state_q == S_DONE))
    else $error("power sequence did not end after eight exponent bits");
`endif

endmodule

`default_nettype wire
